// ===== hdl/dad_pkg.sv =====
// ----------------------------------------------------------------------------
// dad_pkg
// Types and constants shared by the aggregate deframer files.
// ----------------------------------------------------------------------------
package dad_pkg;

  localparam int NUM_GROUPS     = 8;
  localparam int MAX_BANK_WORDS = 65536;

  // enabled bits of the board group mask
  localparam logic [7:0] GROUP_MASK =
    (NUM_GROUPS >= 8) ? 8'hff : 8'((1 << NUM_GROUPS) - 1);

  // saturation point of the undecoded word count
  localparam logic [15:0] SKIP_CAP =
    (MAX_BANK_WORDS < 65535) ? 16'(MAX_BANK_WORDS) : 16'hffff;

  localparam logic [3:0]  BOARD_MARK      = 4'ha;
  localparam logic [27:0] BOARD_HDR_WORDS = 28'd4;
  localparam logic [21:0] CHAN_HDR_WORDS  = 22'd2;

  // format flag positions in the second channel header word
  localparam int FMT_SAMPLES_BIT = 27;
  localparam int FMT_EXTRAS_BIT  = 28;
  localparam int FMT_CHARGE_BIT  = 30;

  localparam int RESQ_DEPTH = 4;
  localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);

  typedef enum logic [2:0] {
    KIND_RECORD = 3'd0,
    KIND_SAMPLE = 3'd1,
    KIND_EXTRAS = 3'd2,
    KIND_CHARGE = 3'd3,
    KIND_GAP    = 3'd4,
    KIND_STATUS = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_COMPLETE = 2'd0,
    STATUS_BAD_HDR  = 2'd1,
    STATUS_INSIDE   = 2'd2
  } status_e;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  group;
    logic [31:0] chan_header_size;
    logic [31:0] chan_header_format;
    logic [31:0] data_word;
    logic [13:0] sample_even;
    logic [13:0] sample_odd;
    logic        record_last;
    logic [22:0] dropped_count;
    status_e     bank_status;
    logic [15:0] words_left;
    logic        run_last;
  } result_t;

endpackage

// ===== hdl/dad_word_if.sv =====
// ----------------------------------------------------------------------------
// dad_word_if
// Bank word channel: one 32-bit word with an end-of-bank marker.
// ----------------------------------------------------------------------------
interface dad_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic        bank_last;

  modport source (output valid, output word, output bank_last, input ready);
  modport sink   (input valid, input word, input bank_last, output ready);
endinterface

// ===== hdl/dad_result_if.sv =====
// ----------------------------------------------------------------------------
// dad_result_if
// Decoded result channel of the aggregate deframer.
// ----------------------------------------------------------------------------
interface dad_result_if;
  import dad_pkg::*;

  logic        valid;
  logic        ready;
  kind_e       kind;
  logic [2:0]  group;
  logic [31:0] chan_header_size;
  logic [31:0] chan_header_format;
  logic [31:0] data_word;
  logic [13:0] sample_even;
  logic [13:0] sample_odd;
  logic        record_last;
  logic [22:0] dropped_count;
  status_e     bank_status;
  logic [15:0] words_left;
  logic        run_last;

  modport source (
    output valid, output kind, output group, output chan_header_size,
    output chan_header_format, output data_word, output sample_even,
    output sample_odd, output record_last, output dropped_count,
    output bank_status, output words_left, output run_last,
    input ready
  );
  modport sink (
    input valid, input kind, input group, input chan_header_size,
    input chan_header_format, input data_word, input sample_even,
    input sample_odd, input record_last, input dropped_count,
    input bank_status, input words_left, input run_last,
    output ready
  );
endinterface

// ===== hdl/dad_core.sv =====
// ----------------------------------------------------------------------------
// dad_core
// Parse state and combinational decode of one bank word into up to two results.
// ----------------------------------------------------------------------------
module dad_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [31:0]      word_i,
  input  logic             bank_last_i,
  output logic [1:0]       count_o,
  output dad_pkg::result_t first_o,
  output dad_pkg::result_t second_o
);
  import dad_pkg::*;

  typedef enum logic [3:0] {
    PH_BOARD0  = 4'd0,
    PH_BOARD1  = 4'd1,
    PH_BOARD2  = 4'd2,
    PH_BOARD3  = 4'd3,
    PH_CH0     = 4'd4,
    PH_CH1     = 4'd5,
    PH_TIME    = 4'd6,
    PH_SAMPLES = 4'd7,
    PH_EXTRAS  = 4'd8,
    PH_CHARGE  = 4'd9,
    PH_PAD     = 4'd10,
    PH_SKIP    = 4'd11
  } phase_e;

  phase_e       phase_q, phase_d;
  logic [27:0]  board_rem_q, board_rem_d;
  logic [21:0]  group_rem_q, group_rem_d;
  logic [7:0]   pending_q, pending_d;
  logic [2:0]   group_q, group_d;
  logic [31:0]  size_hdr_q, size_hdr_d;
  logic [31:0]  fmt_hdr_q, fmt_hdr_d;
  logic [17:0]  samp_rem_q, samp_rem_d;
  logic [22:0]  prev_count_q, prev_count_d;
  logic         count_seen_q, count_seen_d;
  logic [15:0]  skipped_q, skipped_d;

  logic         in_board, in_chan;
  logic [27:0]  board_dec;
  logic [27:0]  board_size;
  logic [21:0]  chan_size;
  logic [22:0]  board_count;
  logic [7:0]   pending_left;
  logic [3:0]   pick;
  logic         prim_valid;
  result_t      prim;
  result_t      status;

  // lowest pending group: {found, index}
  function automatic logic [3:0] lowest_group(input logic [7:0] mask);
    logic [3:0] sel;
    sel = 4'd0;
    for (int i = 7; i >= 0; i--) begin
      if (mask[i]) begin
        sel = {1'b1, 3'(i)};
      end
    end
    return sel;
  endfunction

  function automatic phase_e next_in_record(input phase_e from, input logic [17:0] samp,
                                            input logic [31:0] fmt);
    phase_e nxt;
    if (from <= PH_SAMPLES && samp != '0) begin
      nxt = PH_SAMPLES;
    end else if (from < PH_EXTRAS && fmt[FMT_EXTRAS_BIT]) begin
      nxt = PH_EXTRAS;
    end else if (from < PH_CHARGE && fmt[FMT_CHARGE_BIT]) begin
      nxt = PH_CHARGE;
    end else begin
      nxt = PH_TIME;
    end
    return nxt;
  endfunction

  assign in_board  = (phase_q >= PH_BOARD1) && (phase_q <= PH_PAD);
  assign in_chan   = (phase_q >= PH_CH0) && (phase_q <= PH_CHARGE);
  assign board_dec = (in_board && board_rem_q != '0) ? board_rem_q - 28'd1 : board_rem_q;

  always_comb begin
    phase_d      = phase_q;
    board_rem_d  = board_dec;
    group_rem_d  = group_rem_q;
    pending_d    = pending_q;
    group_d      = group_q;
    size_hdr_d   = size_hdr_q;
    fmt_hdr_d    = fmt_hdr_q;
    samp_rem_d   = samp_rem_q;
    prev_count_d = prev_count_q;
    count_seen_d = count_seen_q;
    skipped_d    = skipped_q;
    prim_valid   = 1'b0;
    prim         = '0;
    status       = '0;
    board_size   = word_i[27:0];
    chan_size    = word_i[21:0];
    board_count  = word_i[22:0];
    pending_left = '0;
    pick         = '0;

    if (phase_q >= PH_CH1 && phase_q <= PH_CHARGE && group_rem_q != '0) begin
      group_rem_d = group_rem_q - 22'd1;
    end

    unique case (phase_q)
      PH_BOARD0: begin
        if (word_i[31:28] != BOARD_MARK) begin
          phase_d   = PH_SKIP;
          skipped_d = 16'd1;
        end else begin
          if (board_size < BOARD_HDR_WORDS) begin
            board_size = BOARD_HDR_WORDS;
          end
          board_rem_d = board_size - 28'd1;
          phase_d     = PH_BOARD1;
        end
      end
      PH_BOARD1: begin
        pending_d = word_i[7:0] & GROUP_MASK;
        phase_d   = PH_BOARD2;
      end
      PH_BOARD2: begin
        if (count_seen_q && {1'b0, board_count} > {1'b0, prev_count_q} + 24'd1) begin
          prim_valid         = 1'b1;
          prim.kind          = KIND_GAP;
          prim.dropped_count = board_count - prev_count_q - 23'd1;
        end
        prev_count_d = board_count;
        count_seen_d = 1'b1;
        phase_d      = PH_BOARD3;
      end
      PH_BOARD3: begin
        pick = lowest_group(pending_q);
        if (pick[3]) begin
          group_d = pick[2:0];
          phase_d = PH_CH0;
        end else begin
          phase_d = PH_PAD;
        end
      end
      PH_CH0: begin
        if (chan_size < CHAN_HDR_WORDS) begin
          chan_size = CHAN_HDR_WORDS;
        end
        size_hdr_d  = word_i;
        group_rem_d = chan_size - 22'd1;
        phase_d     = PH_CH1;
      end
      PH_CH1: begin
        fmt_hdr_d = word_i;
        phase_d   = PH_TIME;
      end
      PH_TIME: begin
        prim_valid     = 1'b1;
        prim.kind      = KIND_RECORD;
        prim.data_word = word_i;
        samp_rem_d     = fmt_hdr_q[FMT_SAMPLES_BIT] ? {fmt_hdr_q[15:0], 2'b00} : '0;
        phase_d        = next_in_record(PH_TIME, samp_rem_d, fmt_hdr_q);
      end
      PH_SAMPLES: begin
        prim_valid       = 1'b1;
        prim.kind        = KIND_SAMPLE;
        prim.sample_even = word_i[13:0];
        prim.sample_odd  = word_i[29:16];
        if (samp_rem_q != '0) begin
          samp_rem_d = samp_rem_q - 18'd1;
        end
        phase_d = next_in_record(PH_SAMPLES, samp_rem_d, fmt_hdr_q);
      end
      PH_EXTRAS: begin
        prim_valid     = 1'b1;
        prim.kind      = KIND_EXTRAS;
        prim.data_word = word_i;
        phase_d        = next_in_record(PH_EXTRAS, samp_rem_q, fmt_hdr_q);
      end
      PH_CHARGE: begin
        prim_valid     = 1'b1;
        prim.kind      = KIND_CHARGE;
        prim.data_word = word_i;
        phase_d        = next_in_record(PH_CHARGE, samp_rem_q, fmt_hdr_q);
      end
      PH_PAD: begin
      end
      default: begin
        // skipping the rest of a bank after a bad header
        if (skipped_q < SKIP_CAP) begin
          skipped_d = skipped_q + 16'd1;
        end
      end
    endcase

    // channel aggregate used up: move on to the next pending group
    if (in_chan && group_rem_d == '0) begin
      pending_left = pending_d & ~(8'd1 << group_q);
      pending_d    = pending_left;
      samp_rem_d   = '0;
      pick         = lowest_group(pending_left);
      if (pick[3]) begin
        group_d = pick[2:0];
        phase_d = PH_CH0;
      end else begin
        phase_d = PH_PAD;
      end
    end

    // board end wins over anything inside it
    if (in_board && board_dec == '0) begin
      samp_rem_d = '0;
      phase_d    = PH_BOARD0;
    end

    if (prim.kind != KIND_GAP) begin
      prim.group              = group_d;
      prim.chan_header_size   = size_hdr_q;
      prim.chan_header_format = fmt_hdr_q;
      prim.record_last = !((phase_d >= PH_SAMPLES) && (phase_d <= PH_CHARGE) && !bank_last_i);
    end
    prim.run_last = !bank_last_i;

    status.kind     = KIND_STATUS;
    status.run_last = 1'b1;
    if (phase_d == PH_SKIP) begin
      status.bank_status = STATUS_BAD_HDR;
      status.words_left  = skipped_d;
    end else if (phase_d == PH_BOARD0) begin
      status.bank_status = STATUS_COMPLETE;
    end else begin
      status.bank_status = STATUS_INSIDE;
    end

    // bank end clears the parse, the board count survives
    if (bank_last_i) begin
      phase_d     = PH_BOARD0;
      board_rem_d = '0;
      group_rem_d = '0;
      pending_d   = '0;
      group_d     = '0;
      size_hdr_d  = '0;
      fmt_hdr_d   = '0;
      samp_rem_d  = '0;
      skipped_d   = '0;
    end
  end

  assign count_o  = {1'b0, prim_valid} + {1'b0, bank_last_i};
  assign first_o  = prim_valid ? prim : status;
  assign second_o = status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_BOARD0;
      board_rem_q  <= '0;
      group_rem_q  <= '0;
      pending_q    <= '0;
      group_q      <= '0;
      size_hdr_q   <= '0;
      fmt_hdr_q    <= '0;
      samp_rem_q   <= '0;
      prev_count_q <= '0;
      count_seen_q <= 1'b0;
      skipped_q    <= '0;
    end else if (take_i) begin
      phase_q      <= phase_d;
      board_rem_q  <= board_rem_d;
      group_rem_q  <= group_rem_d;
      pending_q    <= pending_d;
      group_q      <= group_d;
      size_hdr_q   <= size_hdr_d;
      fmt_hdr_q    <= fmt_hdr_d;
      samp_rem_q   <= samp_rem_d;
      prev_count_q <= prev_count_d;
      count_seen_q <= count_seen_d;
      skipped_q    <= skipped_d;
    end
  end

endmodule

// ===== hdl/dad_result_fifo.sv =====
// ----------------------------------------------------------------------------
// dad_result_fifo
// Small queue: takes up to two results a cycle, gives one a cycle on ready_i.
// ----------------------------------------------------------------------------
module dad_result_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_count_i,
  input  dad_pkg::result_t first_i,
  input  dad_pkg::result_t second_i,
  output logic             room_o,
  output logic             valid_o,
  input  logic             ready_i,
  output dad_pkg::result_t data_o
);
  import dad_pkg::*;

  result_t               entry_q [RESQ_DEPTH];
  logic [RESQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [RESQ_PTR_W:0]   count_q;
  logic                  pop;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = entry_q[rd_ptr_q];
  // room for the worst case of two results from one word
  assign room_o  = (count_q <= (RESQ_PTR_W+1)'(RESQ_DEPTH - 2));

  always_ff @(posedge clk_i) begin
    if (push_count_i != 2'd0) begin
      entry_q[wr_ptr_q] <= first_i;
    end
    if (push_count_i == 2'd2) begin
      entry_q[wr_ptr_q + RESQ_PTR_W'(1)] <= second_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + RESQ_PTR_W'(push_count_i);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + RESQ_PTR_W'(1);
      end
      count_q <= count_q + (RESQ_PTR_W+1)'(push_count_i) - (RESQ_PTR_W+1)'(pop);
    end
  end

endmodule

// ===== hdl/digitizer_aggregate_deframer.sv =====
// ----------------------------------------------------------------------------
// digitizer_aggregate_deframer
// Walks board aggregates, channel aggregates and records of a digitizer bank.
// ----------------------------------------------------------------------------
//
//   channel   direction   payload                                  transfer
//   in_i      sink        word, bank_last                          valid & ready
//   out_o     source      kind, group, headers, data, samples,     valid & ready
//                         record_last, dropped_count, status,
//                         words_left, run_last
//
// one bank word per cycle while the queue has room; each word is decoded in
// the cycle it is taken, and its results, at most two, go to a four-entry result queue
// in_i.ready is high while the queue has room for two results; with out_o
// stalled, three or four results collect before the input stops
// a word with two results (gap, record, sample, extras or charge plus bank status)
// gives them on out_o in turn; results are registered in the queue before out_o
// rst_ni clears the parse state, the board count history and the queue
//
module digitizer_aggregate_deframer (
  input  logic  clk_i,
  input  logic  rst_ni,
  dad_word_if.sink     in_i,
  dad_result_if.source out_o
);
  import dad_pkg::*;

  logic       take;
  logic       room;
  logic [1:0] count;
  logic [1:0] push_count;
  result_t    first_res, second_res, head;

  assign in_i.ready = room;
  assign take       = in_i.valid && room;
  assign push_count = take ? count : 2'd0;

  dad_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .word_i      (in_i.word),
    .bank_last_i (in_i.bank_last),
    .count_o     (count),
    .first_o     (first_res),
    .second_o    (second_res)
  );

  dad_result_fifo u_resq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_count_i (push_count),
    .first_i      (first_res),
    .second_i     (second_res),
    .room_o       (room),
    .valid_o      (out_o.valid),
    .ready_i      (out_o.ready),
    .data_o       (head)
  );

  assign out_o.kind               = head.kind;
  assign out_o.group              = head.group;
  assign out_o.chan_header_size   = head.chan_header_size;
  assign out_o.chan_header_format = head.chan_header_format;
  assign out_o.data_word          = head.data_word;
  assign out_o.sample_even        = head.sample_even;
  assign out_o.sample_odd         = head.sample_odd;
  assign out_o.record_last        = head.record_last;
  assign out_o.dropped_count      = head.dropped_count;
  assign out_o.bank_status        = head.bank_status;
  assign out_o.words_left         = head.words_left;
  assign out_o.run_last           = head.run_last;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the aggregate deframer. Banks of digitizer words
// go in through the word channel: a few hand-built banks first, then random
// banks of nested board and channel aggregates, both well formed and broken.
// A bit-exact model of the walker predicts every result. Each result taken
// from the result channel is compared field by field with the oldest
// prediction, under random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dad_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 200;

  typedef enum logic [3:0] {
    WALK_BOARD_SIZE,
    WALK_BOARD_MASK,
    WALK_BOARD_COUNT,
    WALK_BOARD_TAG,
    WALK_CHAN_SIZE,
    WALK_CHAN_FORMAT,
    WALK_TIME,
    WALK_SAMPLES,
    WALK_EXTRAS,
    WALK_CHARGE,
    WALK_PAD,
    WALK_SKIP
  } walk_phase_e;

  logic clk_i;
  logic rst_ni;

  dad_word_if   word_ch ();
  dad_result_if result_ch ();

  digitizer_aggregate_deframer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (word_ch),
    .out_o  (result_ch)
  );

  // walker state of the model
  walk_phase_e walk_phase;
  logic [27:0] board_left;
  logic [21:0] chan_left;
  logic [7:0]  groups_open;
  logic [2:0]  cur_group;
  logic [31:0] chan_size;
  logic [31:0] chan_format;
  logic [17:0] samples_left;
  logic [22:0] last_count = '0;
  logic        count_seen = 1'b0;
  logic [15:0] skipped;

  result_t     decoded_q[$];
  logic [31:0] bank_words[$];
  logic [22:0] plan_count;

  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;
  int hold_left         = 0;
  int stall_cycles      = 0;
  int mismatches        = 0;
  int items_sent        = 0;
  int banks_seen        = 0;
  int records_seen      = 0;
  int gaps_seen         = 0;
  int bad_banks         = 0;
  int open_banks        = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- model

  function automatic void clear_walk();
    walk_phase   = WALK_BOARD_SIZE;
    board_left   = '0;
    chan_left    = '0;
    groups_open  = '0;
    cur_group    = '0;
    chan_size    = '0;
    chan_format  = '0;
    samples_left = '0;
    skipped      = '0;
  endfunction

  // lowest open group next, or padding once none is left
  function automatic void pick_next_group();
    logic found;
    found = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!found && groups_open[i]) begin
        found     = 1'b1;
        cur_group = 3'(i);
      end
    end
    walk_phase = found ? WALK_CHAN_SIZE : WALK_PAD;
  endfunction

  function automatic walk_phase_e record_step_after(walk_phase_e from);
    if (from <= WALK_SAMPLES && samples_left != 0) return WALK_SAMPLES;
    if (from < WALK_EXTRAS && chan_format[FMT_EXTRAS_BIT]) return WALK_EXTRAS;
    if (from < WALK_CHARGE && chan_format[FMT_CHARGE_BIT]) return WALK_CHARGE;
    return WALK_TIME;
  endfunction

  function automatic void deframe_word(logic [31:0] w, logic is_last);
    result_t     r[2];
    int          n;
    int          rec;
    walk_phase_e ph;
    logic [27:0] bsize;
    logic [21:0] csize;
    logic [22:0] cnt;
    n    = 0;
    rec  = -1;
    ph   = walk_phase;
    r[0] = '0;
    r[1] = '0;

    if (ph >= WALK_BOARD_MASK && ph <= WALK_PAD && board_left != 0) board_left--;
    if (ph >= WALK_CHAN_FORMAT && ph <= WALK_CHARGE && chan_left != 0) chan_left--;

    case (ph)
      WALK_BOARD_SIZE: begin
        if (w[31:28] != BOARD_MARK) begin
          walk_phase = WALK_SKIP;
          skipped    = 16'd1;
        end else begin
          bsize = w[27:0];
          if (bsize < BOARD_HDR_WORDS) bsize = BOARD_HDR_WORDS;
          board_left = bsize - 28'd1;
          walk_phase = WALK_BOARD_MASK;
        end
      end
      WALK_BOARD_MASK: begin
        groups_open = w[7:0] & GROUP_MASK;
        walk_phase  = WALK_BOARD_COUNT;
      end
      WALK_BOARD_COUNT: begin
        cnt = w[22:0];
        if (count_seen && 32'(cnt) > 32'(last_count) + 32'd1) begin
          r[n].kind          = KIND_GAP;
          r[n].dropped_count = cnt - last_count - 23'd1;
          n++;
        end
        last_count = cnt;
        count_seen = 1'b1;
        walk_phase = WALK_BOARD_TAG;
      end
      WALK_BOARD_TAG: pick_next_group();
      WALK_CHAN_SIZE: begin
        csize = w[21:0];
        if (csize < CHAN_HDR_WORDS) csize = CHAN_HDR_WORDS;
        chan_size  = w;
        chan_left  = csize - 22'd1;
        walk_phase = WALK_CHAN_FORMAT;
      end
      WALK_CHAN_FORMAT: begin
        chan_format = w;
        walk_phase  = WALK_TIME;
      end
      WALK_TIME: begin
        rec = n++;
        r[rec].kind      = KIND_RECORD;
        r[rec].data_word = w;
        samples_left = chan_format[FMT_SAMPLES_BIT] ? {chan_format[15:0], 2'b00} : '0;
        walk_phase   = record_step_after(WALK_TIME);
      end
      WALK_SAMPLES: begin
        rec = n++;
        r[rec].kind        = KIND_SAMPLE;
        r[rec].sample_even = w[13:0];
        r[rec].sample_odd  = w[29:16];
        if (samples_left != 0) samples_left--;
        walk_phase = record_step_after(WALK_SAMPLES);
      end
      WALK_EXTRAS: begin
        rec = n++;
        r[rec].kind      = KIND_EXTRAS;
        r[rec].data_word = w;
        walk_phase = record_step_after(WALK_EXTRAS);
      end
      WALK_CHARGE: begin
        rec = n++;
        r[rec].kind      = KIND_CHARGE;
        r[rec].data_word = w;
        walk_phase = record_step_after(WALK_CHARGE);
      end
      WALK_PAD: ;
      default: begin
        if (skipped < SKIP_CAP) skipped++;
      end
    endcase

    // channel end first, then board end overrides it
    if (ph >= WALK_CHAN_SIZE && ph <= WALK_CHARGE && chan_left == 0) begin
      groups_open[cur_group] = 1'b0;
      samples_left = '0;
      pick_next_group();
    end
    if (ph >= WALK_BOARD_MASK && ph <= WALK_PAD && board_left == 0) begin
      samples_left = '0;
      walk_phase   = WALK_BOARD_SIZE;
    end

    if (rec >= 0) begin
      r[rec].group              = cur_group;
      r[rec].chan_header_size   = chan_size;
      r[rec].chan_header_format = chan_format;
      r[rec].record_last = (walk_phase >= WALK_SAMPLES && walk_phase <= WALK_CHARGE &&
                            !is_last) ? 1'b0 : 1'b1;
    end

    if (is_last) begin
      r[n].kind = KIND_STATUS;
      if (walk_phase == WALK_SKIP) begin
        r[n].bank_status = STATUS_BAD_HDR;
        r[n].words_left  = skipped;
      end else if (walk_phase == WALK_BOARD_SIZE) begin
        r[n].bank_status = STATUS_COMPLETE;
      end else begin
        r[n].bank_status = STATUS_INSIDE;
      end
      n++;
      clear_walk();
    end

    if (n > 0) r[n - 1].run_last = 1'b1;
    for (int i = 0; i < n; i++) begin
      decoded_q = {decoded_q, r[i]};
      case (r[i].kind)
        KIND_RECORD: records_seen++;
        KIND_GAP:    gaps_seen++;
        KIND_STATUS: begin
          banks_seen++;
          if (r[i].bank_status == STATUS_BAD_HDR) bad_banks++;
          if (r[i].bank_status == STATUS_INSIDE) open_banks++;
        end
        default: ;
      endcase
    end
  endfunction

  // ------------------------------------------------------------- stimulus

  task automatic send_word(input logic [31:0] w, input logic is_last);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      word_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    word_ch.valid     = 1'b1;
    word_ch.word      = w;
    word_ch.bank_last = is_last;
    do @(posedge clk_i); while (!word_ch.ready);
    deframe_word(w, is_last);
    items_sent++;
  endtask

  task automatic send_bank();
    for (int i = 0; i < bank_words.size(); i++)
      send_word(bank_words[i], i == bank_words.size() - 1);
  endtask

  function automatic void append_word(input logic [31:0] w);
    bank_words = {bank_words, w};
  endfunction

  // records of one channel aggregate, sometimes with a size that disagrees
  function automatic void add_channel();
    logic [31:0] fmt;
    logic [31:0] size_w;
    logic        has_samples;
    logic        has_extras;
    logic        has_charge;
    int          nsamp;
    int          nrec;
    int          body;
    int          csize;
    int          shape;
    has_samples = 1'($urandom_range(0, 1));
    has_extras  = 1'($urandom_range(0, 1));
    has_charge  = 1'($urandom_range(0, 1));
    nsamp = ($urandom_range(0, 7) == 0) ? 2 : $urandom_range(0, 1);
    fmt   = $urandom;
    fmt[FMT_SAMPLES_BIT] = has_samples;
    fmt[FMT_EXTRAS_BIT]  = has_extras;
    fmt[FMT_CHARGE_BIT]  = has_charge;
    fmt[15:0] = 16'(nsamp);
    nrec  = $urandom_range(1, 3);
    body  = nrec * (1 + (has_samples ? 4 * nsamp : 0) + has_extras + has_charge);
    csize = 2 + body;
    shape = $urandom_range(0, 19);
    if (shape == 0) begin
      csize = $urandom_range(0, 1);
    end else if (shape == 1) begin
      csize = 2 + $urandom_range(0, body - 1);
    end else if (shape == 2) begin
      // leftover channel words open another record
      csize += $urandom_range(1, 3);
      body = csize - 2;
    end
    size_w = $urandom;
    size_w[21:0] = 22'(csize);
    append_word(size_w);
    append_word(fmt);
    repeat (body) append_word($urandom);
  endfunction

  function automatic void add_board(input logic [7:0] mask_min);
    logic [31:0] mask_w;
    logic [31:0] cnt_w;
    logic [22:0] cnt;
    int          start;
    int          nwords;
    int          bsize;
    int          shape;
    int          npad;
    shape = $urandom_range(0, 19);
    if (shape < 2) cnt = plan_count + 23'($urandom_range(2, 5000));
    else if (shape == 2) cnt = 23'($urandom);
    else if (shape == 3) cnt = plan_count - 23'($urandom_range(1, 100));
    else cnt = plan_count + 23'd1;
    plan_count = cnt;
    mask_w = $urandom;
    mask_w[7:0] = 8'($urandom & $urandom) | mask_min;
    cnt_w = $urandom;
    cnt_w[22:0] = cnt;
    start = bank_words.size();
    append_word(32'd0);
    append_word(mask_w);
    append_word(cnt_w);
    append_word($urandom);
    for (int g = 0; g < 8; g++)
      if (mask_w[g]) add_channel();
    nwords = bank_words.size() - start;
    bsize  = nwords;
    shape  = $urandom_range(0, 19);
    if (shape == 0) begin
      bsize = $urandom_range(0, 3);
    end else if (shape == 1) begin
      bsize = $urandom_range(4, nwords);
    end else if (shape == 2) begin
      npad = $urandom_range(1, 3);
      repeat (npad) append_word($urandom);
      bsize += npad;
    end
    bank_words[start] = {BOARD_MARK, 28'(bsize)};
  endfunction

  task automatic send_random_bank();
    logic [31:0] bad_w;
    int          shape;
    int          cut;
    bank_words.delete();
    plan_count = last_count;
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      repeat ($urandom_range(1, 4)) append_word($urandom);
    end else begin
      repeat ($urandom_range(1, 3)) add_board(8'h00);
      if (shape == 1) begin
        cut = $urandom_range(1, bank_words.size());
        while (bank_words.size() > cut) void'(bank_words.pop_back());
      end else if (shape == 2) begin
        bad_w = $urandom;
        if (bad_w[31:28] == BOARD_MARK) bad_w[31:28] = ~BOARD_MARK;
        append_word(bad_w);
        repeat ($urandom_range(0, 3)) append_word($urandom);
      end
    end
    send_bank();
  endtask

  // ----------------------------------------------------------------- tests

  task automatic test_bad_header();
    bank_words = '{32'h0000_0000};
    send_bank();
    bank_words = '{32'hb000_0000, 32'ha000_0004};
    send_bank();
  endtask

  // size below the header size, full mask, board ends on its time tag
  task automatic test_minimal_board();
    bank_words = '{32'ha000_0000, 32'h0000_00ff, 32'hff80_0000, 32'hffff_ffff};
    send_bank();
  endtask

  // one record with samples, extras and charge in group 7, widest counter gap
  task automatic test_full_record();
    bank_words = '{32'ha000_000d, 32'hffff_ff80, 32'hffff_ffff, 32'h1234_5678,
                   32'hffc0_0009, 32'h5800_0001, 32'hdead_beef,
                   32'hffff_ffff, 32'h0000_0000, 32'h3fff_3fff, 32'hc000_c000,
                   32'h0000_ffff, 32'hffff_0000};
    send_bank();
  endtask

  // largest sizes, bank ends on a time word inside the record
  task automatic test_unfinished_bank();
    bank_words = '{32'hafff_ffff, 32'h0000_0001, 32'hff7f_ffff, 32'h0000_0000,
                   32'h003f_ffff, 32'hffff_ffff, 32'h8000_0000};
    send_bank();
  endtask

  task automatic test_random_banks(input int send_pct, input int recv_pct, input int n_items);
    int target;
    sender_idle_pct   = send_pct;
    receiver_idle_pct = recv_pct;
    target = items_sent + n_items;
    while (items_sent < target) send_random_bank();
  endtask

  // result side held off while the sender keeps offering record words
  task automatic test_output_stall();
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    bank_words.delete();
    plan_count = last_count;
    add_board(8'h0f);
    add_board(8'h0f);
    hold_left = 150;
    send_bank();
  endtask

  // ------------------------------------------------------- result checking

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : result_monitor
    result_t want;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (decoded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t ns: result with nothing expected, expected none, got kind %0d",
                   $time, result_ch.kind);
      end else begin
        want = decoded_q.pop_front();
        check_field("kind", want.kind, result_ch.kind);
        check_field("group", want.group, result_ch.group);
        check_field("chan_header_size", want.chan_header_size, result_ch.chan_header_size);
        check_field("chan_header_format", want.chan_header_format,
                    result_ch.chan_header_format);
        check_field("data_word", want.data_word, result_ch.data_word);
        check_field("sample_even", want.sample_even, result_ch.sample_even);
        check_field("sample_odd", want.sample_odd, result_ch.sample_odd);
        check_field("record_last", want.record_last, result_ch.record_last);
        check_field("dropped_count", want.dropped_count, result_ch.dropped_count);
        check_field("bank_status", want.bank_status, result_ch.bank_status);
        check_field("words_left", want.words_left, result_ch.words_left);
        check_field("run_last", want.run_last, result_ch.run_last);
      end
    end
  end

  // receiver: random idling, or a long hold-off counted here
  initial begin
    result_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        result_ch.ready = 1'b0;
        hold_left--;
      end else begin
        result_ch.ready = ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (word_ch.valid && word_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                 $time, stall_cycles, decoded_q.size());
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    word_ch.valid     = 1'b0;
    word_ch.word      = '0;
    word_ch.bank_last = 1'b0;
    rst_ni            = 1'b0;
    clear_walk();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_bad_header();
    test_minimal_board();
    test_full_record();
    test_unfinished_bank();
    test_random_banks(37, 52, 370);
    test_random_banks(52, 37, 370);
    test_random_banks(0, 0, 370);
    test_output_stall();

    @(negedge clk_i);
    word_ch.valid = 1'b0;
    receiver_idle_pct = 0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("covered %0d bank words in %0d banks: %0d records, %0d counter gaps,",
             items_sent, banks_seen, records_seen, gaps_seen);
    $display("%0d banks stopped at a bad header, %0d ended inside an aggregate",
             bad_banks, open_banks);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
